// File: rtl/bpsu_pkg.sv
// Shared types and constants for the BMP pixel stream unpacker.
// No dependencies; every other file in rtl/ depends on this package.
`default_nettype none

package bpsu_pkg;

  // Largest image dimension in pixels; larger header values are clamped
  localparam int MAX_DIM     = 4096;
  localparam int DIM_W       = $clog2(MAX_DIM) + 1;   // magnitude 0..MAX_DIM
  localparam int CNT_W       = $clog2(MAX_DIM);       // column / row counters
  localparam int CFG_DATA_W  = 14;
  localparam int CFG_INDEX_W = 3;
  localparam int SIZE_W      = 14;
  localparam int ORIGIN_W    = 12;
  localparam int COORD_W     = 13;
  localparam int COLOR_W     = 32;

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_HAS_ALPHA    = 3'd2,
    CFG_ORIGIN_X     = 3'd3,
    CFG_ORIGIN_Y     = 3'd4
  } cfg_reg_t;

  // Byte position inside one pixel
  typedef enum logic [1:0] {
    PH_BLUE  = 2'd0,
    PH_GREEN = 2'd1,
    PH_RED   = 2'd2,
    PH_ALPHA = 2'd3
  } phase_t;

  // Geometry handed to the coordinate mapper
  typedef struct packed {
    logic [DIM_W-1:0]    w_mag;
    logic                w_neg;
    logic [DIM_W-1:0]    h_mag;
    logic                h_neg;
    logic [ORIGIN_W-1:0] origin_x;
    logic [ORIGIN_W-1:0] origin_y;
  } geom_t;

  // Mapped coordinate and end-of-row / end-of-image flags
  typedef struct packed {
    logic [COORD_W-1:0] screen_x;
    logic [COORD_W-1:0] screen_y;
    logic               last_col;
    logic               last_row;
  } coord_t;

  // Magnitude of a signed header dimension, clamped to MAX_DIM
  function automatic logic [DIM_W-1:0] dim_mag(input logic [SIZE_W-1:0] raw);
    logic [SIZE_W-1:0] m;
    m = raw[SIZE_W-1] ? (SIZE_W'(0) - raw) : raw;
    if (m > SIZE_W'(MAX_DIM)) begin
      m = SIZE_W'(MAX_DIM);
    end
    return m[DIM_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/bpsu_if.sv
// Valid/ready channel interfaces: raw byte input and mapped pixel output.
// Depends on bpsu_pkg for field widths.
`default_nettype none

interface bpsu_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_byte;

  modport source (output valid, output pixel_byte, input ready);
  modport sink   (input valid, input pixel_byte, output ready);
endinterface

interface bpsu_pixel_if;
  logic                           valid;
  logic                           ready;
  logic [bpsu_pkg::COORD_W-1:0]   screen_x;
  logic [bpsu_pkg::COORD_W-1:0]   screen_y;
  logic [bpsu_pkg::COLOR_W-1:0]   argb_color;
  logic                           image_done;

  modport source (output valid, output screen_x, output screen_y, output argb_color,
                  output image_done, input ready);
  modport sink   (input valid, input screen_x, input screen_y, input argb_color,
                  input image_done, output ready);
endinterface

`default_nettype wire

// File: rtl/bpsu_coord.sv
// Coordinate mapper: turns column/row counters into screen coordinates,
// honoring mirrored rows and bottom-up images. Depends on bpsu_pkg.
`default_nettype none

module bpsu_coord (
  input  bpsu_pkg::geom_t                geom,
  input  logic [bpsu_pkg::CNT_W-1:0]     column_count,
  input  logic [bpsu_pkg::CNT_W-1:0]     row_count,
  output bpsu_pkg::coord_t               coord
);
  import bpsu_pkg::*;

  logic [COORD_W-1:0] col_ext;
  logic [COORD_W-1:0] row_ext;
  logic [COORD_W-1:0] ox_ext;
  logic [COORD_W-1:0] oy_ext;
  logic [COORD_W-1:0] w_ext;
  logic [COORD_W-1:0] h_ext;
  logic [DIM_W-1:0]   col_inc;
  logic [DIM_W-1:0]   row_inc;

  assign col_ext = COORD_W'(column_count);
  assign row_ext = COORD_W'(row_count);
  assign ox_ext  = COORD_W'(geom.origin_x);
  assign oy_ext  = COORD_W'(geom.origin_y);
  assign w_ext   = COORD_W'(geom.w_mag);
  assign h_ext   = COORD_W'(geom.h_mag);
  assign col_inc = DIM_W'(column_count) + DIM_W'(1);
  assign row_inc = DIM_W'(row_count) + DIM_W'(1);

  // Map counters to the screen; sums wrap at the coordinate width
  always_comb begin
    coord.screen_x = geom.w_neg ? (ox_ext + w_ext - COORD_W'(1) - col_ext)
                                : (ox_ext + col_ext);
    coord.screen_y = geom.h_neg ? (oy_ext + row_ext)
                                : (oy_ext + h_ext - COORD_W'(1) - row_ext);
    coord.last_col = (col_inc >= geom.w_mag);
    coord.last_row = (row_inc >= geom.h_mag);
  end

endmodule

`default_nettype wire

// File: rtl/bmp_pixel_stream_unpacker_core.sv
// Top level of the BMP pixel stream unpacker: configuration registers,
// byte assembly, row/padding counters and the output register.
// Depends on bpsu_pkg, bpsu_if (interfaces) and bpsu_coord.
//
//  channel    dir  handshake      payload
//  byte_in    in   valid/ready    pixel_byte[7:0]
//  pixel_out  out  valid/ready    screen_x[12:0] screen_y[12:0] argb_color[31:0] image_done
//  cfg        in   cfg_we only    cfg_index[2:0] cfg_data[13:0]
//
// One byte is taken per clock; a finished pixel appears on pixel_out the cycle after
// its last byte is taken. The single output register sets the rate: a byte is taken
// whenever that register is empty or being drained in the same cycle.
// Synchronous reset restores the header defaults (800 x 480, 24-bit) and clears counters.
// A stalled pixel_out holds its pixel and blocks every byte, padding included, until
// that pixel transfers.
`default_nettype none

module bmp_pixel_stream_unpacker_core (
  input  logic                          clk,
  input  logic                          rst,
  bpsu_byte_if.sink                     byte_in,
  bpsu_pixel_if.source                  pixel_out,
  input  logic                          cfg_we,
  input  bpsu_pkg::cfg_index_t          cfg_index,
  input  bpsu_pkg::cfg_data_t           cfg_data
);
  import bpsu_pkg::*;

  // Configuration registers
  logic [SIZE_W-1:0]   image_width;
  logic [SIZE_W-1:0]   image_height;
  logic                has_alpha;
  logic [ORIGIN_W-1:0] origin_x;
  logic [ORIGIN_W-1:0] origin_y;

  // Stream state
  phase_t              byte_phase;
  logic [15:0]         partial_color;
  logic [CNT_W-1:0]    column_count;
  logic [CNT_W-1:0]    row_count;
  logic [1:0]          pad_remaining;
  logic [7:0]          red_byte;
  logic [7:0]          red_sel;

  // Output register
  logic                out_valid;
  logic [COORD_W-1:0]  out_x;
  logic [COORD_W-1:0]  out_y;
  logic [COLOR_W-1:0]  out_color;
  logic                out_done;

  geom_t               geom;
  coord_t              coord;
  logic                in_fire;
  logic                dim_zero;
  logic                emit;
  logic [7:0]          alpha;
  logic [7:0]          data;

  // Hold configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= SIZE_W'(800);
      image_height <= SIZE_W'(480);
      has_alpha    <= 1'b0;
      origin_x     <= '0;
      origin_y     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data[SIZE_W-1:0];
        CFG_IMAGE_HEIGHT: image_height <= cfg_data[SIZE_W-1:0];
        CFG_HAS_ALPHA:    has_alpha    <= cfg_data[0];
        CFG_ORIGIN_X:     origin_x     <= cfg_data[ORIGIN_W-1:0];
        CFG_ORIGIN_Y:     origin_y     <= cfg_data[ORIGIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Decode geometry
  always_comb begin
    geom.w_mag    = dim_mag(image_width);
    geom.w_neg    = image_width[SIZE_W-1];
    geom.h_mag    = dim_mag(image_height);
    geom.h_neg    = image_height[SIZE_W-1];
    geom.origin_x = origin_x;
    geom.origin_y = origin_y;
  end

  bpsu_coord u_coord (
    .geom         (geom),
    .column_count (column_count),
    .row_count    (row_count),
    .coord        (coord)
  );

  // Accept a byte whenever the output register is free or draining
  assign byte_in.ready = !out_valid || pixel_out.ready;
  assign in_fire       = byte_in.valid && byte_in.ready;
  assign data          = byte_in.pixel_byte;
  assign dim_zero      = (geom.w_mag == '0) || (geom.h_mag == '0);

  // A pixel completes on red without alpha, or on the alpha byte
  always_comb begin
    emit  = 1'b0;
    alpha = 8'h00;
    if (in_fire && !dim_zero && pad_remaining == 2'd0) begin
      if (byte_phase == PH_ALPHA) begin
        emit  = 1'b1;
        alpha = data;
      end else if (byte_phase == PH_RED && !has_alpha) begin
        emit  = 1'b1;
      end
    end
  end

  // Advance byte assembly, padding and row/column counters
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase    <= PH_BLUE;
      column_count  <= '0;
      row_count     <= '0;
      pad_remaining <= '0;
    end else if (in_fire && !dim_zero) begin
      if (pad_remaining != 2'd0) begin
        pad_remaining <= pad_remaining - 2'd1;
      end else begin
        unique case (byte_phase)
          PH_BLUE:  byte_phase <= PH_GREEN;
          PH_GREEN: byte_phase <= PH_RED;
          PH_RED:   byte_phase <= has_alpha ? PH_ALPHA : PH_BLUE;
          PH_ALPHA: byte_phase <= PH_BLUE;
          default:  byte_phase <= PH_BLUE;
        endcase
        if (emit) begin
          if (coord.last_col) begin
            column_count  <= '0;
            // 24-bit rows need w mod 4 pad bytes; 32-bit rows need none
            pad_remaining <= has_alpha ? 2'd0 : geom.w_mag[1:0];
            row_count     <= coord.last_row ? '0 : row_count + CNT_W'(1);
          end else begin
            column_count  <= column_count + CNT_W'(1);
          end
        end
      end
    end
  end

  // Gather blue and green; hold red for a following alpha byte
  always_ff @(posedge clk) begin
    if (in_fire && !dim_zero && pad_remaining == 2'd0) begin
      if (byte_phase == PH_BLUE) begin
        partial_color[7:0] <= data;
      end
      if (byte_phase == PH_GREEN) begin
        partial_color[15:8] <= data;
      end
      if (byte_phase == PH_RED) begin
        red_byte <= data;
      end
    end
  end

  assign red_sel = (byte_phase == PH_RED) ? data : red_byte;

  // Load the output register on a finished pixel; drop valid on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (pixel_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_x     <= coord.screen_x;
      out_y     <= coord.screen_y;
      out_color <= {alpha, red_sel, partial_color};
      out_done  <= coord.last_col && coord.last_row;
    end
  end

  assign pixel_out.valid      = out_valid;
  assign pixel_out.screen_x   = out_x;
  assign pixel_out.screen_y   = out_y;
  assign pixel_out.argb_color = out_color;
  assign pixel_out.image_done = out_done;

  // Padding is only ever pending between pixels
  a_pad_at_pixel_start: assert property (@(posedge clk) disable iff (rst)
    pad_remaining != 2'd0 |-> byte_phase == PH_BLUE)
    else $error("padding pending in the middle of a pixel");

  // A row end clears the column counter
  a_row_end_clears_col: assert property (@(posedge clk) disable iff (rst)
    emit && coord.last_col |=> column_count == '0)
    else $error("column counter not cleared at row end");

  // 32-bit rows never load padding
  a_no_pad_with_alpha: assert property (@(posedge clk) disable iff (rst)
    emit && coord.last_col && has_alpha |=> pad_remaining == 2'd0)
    else $error("padding loaded for a 32-bit row");

  // A new pixel only appears after a byte transfer
  a_pixel_from_byte: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_fire))
    else $error("pixel appeared without a byte transfer");

endmodule

`default_nettype wire
